// ----- rtl/dirty_byte_run_tracker_macros.svh -----
// Assertion macros shared by the dirty byte run tracker RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef DIRTY_BYTE_RUN_TRACKER_MACROS_SVH
`define DIRTY_BYTE_RUN_TRACKER_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define DBRT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DBRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dbrt_pkg.sv -----
// Shared types and constants for the dirty byte run tracker.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package dbrt_pkg;

  localparam int OFFSET_W  = 10;
  localparam int DATA_W    = 64;
  localparam int COUNT_W   = 4;
  localparam int ADDR_W    = 11;
  localparam int RUN_LEN_W = 6;
  localparam int BYTE_W    = 8;
  localparam logic [COUNT_W-1:0] MAX_COUNT = 4'd8;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_MARK  = 2'd1,
    OP_FIND  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FIND_START,
    ST_FIND_RUN,
    ST_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                we;
    logic [OFFSET_W-1:0] waddr;
    logic [BYTE_W-1:0]   wdata;
    logic [OFFSET_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic                 found;
    logic [ADDR_W-1:0]    run_address;
    logic [RUN_LEN_W-1:0] run_length;
    logic [BYTE_W-1:0]    read_value;
    logic                 range_error;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/dbrt_mem.sv -----
// Byte storage of the cluster buffer with one write and one registered read port.
// Depends on dbrt_pkg for the request type.
`default_nettype none

module dbrt_mem
  import dbrt_pkg::*;
#(
  parameter int BUFFER_BYTES = 32
) (
  input  wire logic              clk,
  input  wire mem_req_t          mem_req,
  output logic [BYTE_W-1:0]      rd_data
);

  localparam int IDX_W = $clog2(BUFFER_BYTES);

  logic [BYTE_W-1:0] bytes_r [BUFFER_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      bytes_r[mem_req.waddr[IDX_W-1:0]] <= mem_req.wdata;
    end
    rd_data_r <= bytes_r[mem_req.raddr[IDX_W-1:0]];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/dbrt_ctrl.sv -----
// Sequencer and dirty mask of the tracker: one shared position counter and
// bound compare step through writes and run searches. Depends on dbrt_pkg and the macros header.
`default_nettype none
`include "dirty_byte_run_tracker_macros.svh"

module dbrt_ctrl
  import dbrt_pkg::*;
#(
  parameter int BUFFER_BYTES = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_op,
  input  wire logic [OFFSET_W-1:0] in_offset,
  input  wire logic [DATA_W-1:0]   in_data_bytes,
  input  wire logic [COUNT_W-1:0]  in_byte_count,
  output mem_req_t                 mem_req,
  input  wire logic [BYTE_W-1:0]   mem_rd_data,
  output logic                     res_valid,
  input  wire logic                res_take,
  output result_t                  res
);

  localparam int IDX_W = $clog2(BUFFER_BYTES);
  localparam int LEN_W = IDX_W + 1;
  localparam logic [ADDR_W-1:0] BUF_END = ADDR_W'(BUFFER_BYTES);

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [OFFSET_W-1:0]     offset_r, offset_nxt;
  logic [DATA_W-1:0]       data_r, data_nxt;
  logic [COUNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]       pos_r, pos_nxt;
  logic [IDX_W-1:0]        start_r, start_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic                    err_r, err_nxt;
  logic                    found_r, found_nxt;
  logic [BUFFER_BYTES-1:0] mask_r, mask_nxt;

  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] pos_idx;
  logic             pos_dirty;
  logic             run_hit;
  logic             rd_err;

  assign accept    = in_valid && !in_stall;
  assign in_range  = pos_r < BUF_END;
  assign pos_idx   = pos_r[IDX_W-1:0];
  assign pos_dirty = in_range && mask_r[pos_idx];
  assign run_hit   = pos_dirty;
  assign rd_err    = ADDR_W'(offset_r) >= BUF_END;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_op))
            OP_WRITE: state_nxt = ST_WRITE;
            OP_FIND:  state_nxt = ST_FIND_START;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_WRITE: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FIND_START: begin
        if (!in_range) begin
          state_nxt = ST_FINISH;
        end else if (pos_dirty) begin
          state_nxt = ST_FIND_RUN;
        end
      end
      ST_FIND_RUN: begin
        if (!run_hit) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_READ:   state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = state_r != ST_IDLE;
    res_valid     = state_r == ST_FINISH;
    mem_req.we    = (state_r == ST_WRITE) && (cnt_r != '0) && in_range;
    mem_req.waddr = pos_r[OFFSET_W-1:0];
    mem_req.wdata = data_r[BYTE_W-1:0];
    mem_req.raddr = offset_r;

    res.found       = found_r;
    res.run_address = found_r ? ADDR_W'(offset_r) + ADDR_W'(start_r) : '0;
    res.run_length  = found_r ? RUN_LEN_W'(len_r) : '0;
    res.read_value  = (op_r == OP_READ && !rd_err) ? mem_rd_data : '0;
    case (op_r)
      OP_WRITE: res.range_error = err_r;
      OP_READ:  res.range_error = rd_err;
      default:  res.range_error = 1'b0;
    endcase
  end

  always_comb begin
    op_nxt     = op_r;
    offset_nxt = offset_r;
    data_nxt   = data_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    err_nxt    = err_r;
    found_nxt  = found_r;
    mask_nxt   = mask_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = op_t'(in_op);
          offset_nxt = in_offset;
          data_nxt   = in_data_bytes;
          cnt_nxt    = (in_byte_count > MAX_COUNT) ? MAX_COUNT : in_byte_count;
          err_nxt    = 1'b0;
          found_nxt  = 1'b0;
          len_nxt    = '0;
          start_nxt  = '0;
          if (op_t'(in_op) == OP_WRITE) begin
            pos_nxt = ADDR_W'(in_offset);
          end else begin
            pos_nxt = '0;
          end
          if (op_t'(in_op) == OP_MARK) begin
            mask_nxt = '1;
          end
        end
      end
      ST_WRITE: begin
        if (cnt_r != '0) begin
          if (in_range) begin
            mask_nxt[pos_idx] = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
          pos_nxt  = pos_r + ADDR_W'(1);
          cnt_nxt  = cnt_r - COUNT_W'(1);
          data_nxt = data_r >> BYTE_W;
        end
      end
      ST_FIND_START: begin
        if (pos_dirty) begin
          start_nxt = pos_idx;
        end else if (in_range) begin
          pos_nxt = pos_r + ADDR_W'(1);
        end
      end
      ST_FIND_RUN: begin
        if (run_hit) begin
          mask_nxt[pos_idx] = 1'b0;
          len_nxt           = len_r + LEN_W'(1);
          found_nxt         = 1'b1;
          pos_nxt           = pos_r + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mask_r  <= '0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
    end
    op_r     <= op_nxt;
    offset_r <= offset_nxt;
    data_r   <= data_nxt;
    cnt_r    <= cnt_nxt;
    pos_r    <= pos_nxt;
    start_r  <= start_nxt;
    len_r    <= len_nxt;
    err_r    <= err_nxt;
    found_r  <= found_nxt;
  end

  `DBRT_ASSERT_ALWAYS(a_cnt_bound, (state_r != ST_WRITE) || (cnt_r <= MAX_COUNT), "count over 8")
  `DBRT_ASSERT_ALWAYS(a_found_len, !(state_r == ST_FINISH && found_r) || (len_r != '0), "empty run")
  `DBRT_ASSERT_NEXT(a_run_clear, state_r == ST_FIND_RUN && run_hit, !mask_r[$past(pos_idx)], "bit kept")
  `DBRT_ASSERT_NEXT(a_accept_busy, accept, state_r != ST_IDLE, "accepted word ignored")

endmodule

`default_nettype wire

// ----- rtl/dirty_byte_run_tracker.sv -----
// Dirty byte run tracker: one word at a time. A write stores and marks byte_count
// bytes from the offset (a count above 8 counts as 8), mark-all sets every mask bit,
// read returns one buffer byte, and find steps the shared position counter up from
// index 0 to the first dirty run and clears it. A new word is taken only after the
// last result has passed to the output register, which output stalls can hold back.
// Reset clears the dirty mask and control state; buffer bytes are not cleared.
`default_nettype none

module dirty_byte_run_tracker
  import dbrt_pkg::*;
#(
  parameter int BUFFER_BYTES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_op,
  input  wire logic [OFFSET_W-1:0]  in_offset,
  input  wire logic [DATA_W-1:0]    in_data_bytes,
  input  wire logic [COUNT_W-1:0]   in_byte_count,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_found,
  output logic [ADDR_W-1:0]         out_run_address,
  output logic [RUN_LEN_W-1:0]      out_run_length,
  output logic [BYTE_W-1:0]         out_read_value,
  output logic                      out_range_error
);

  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rd_data;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  result_t           out_res_r;
  logic              out_valid_r, out_valid_nxt;

  dbrt_mem #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (mem_rd_data)
  );

  dbrt_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_offset     (in_offset),
    .in_data_bytes (in_data_bytes),
    .in_byte_count (in_byte_count),
    .mem_req       (mem_req),
    .mem_rd_data   (mem_rd_data),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_res_r.found;
  assign out_run_address = out_res_r.run_address;
  assign out_run_length  = out_res_r.run_length;
  assign out_read_value  = out_res_r.read_value;
  assign out_range_error = out_res_r.range_error;

endmodule

`default_nettype wire
